[rtl/sgw_pkg.sv]
// ----------------------------------------------------------------------------
// Stereo gain / widener / soft clip package
// Shared widths, fixed-point constants, register indexes, state types and
// status structs for the stereo gain, widener and soft clip block.
// ----------------------------------------------------------------------------
package sgw_pkg;

	// Defaults for the top level parameters.
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEFF_BITS_DEF  = 16;

	// Configuration register widths and port shape.
	localparam int GAIN_W     = 24;
	localparam int BOOST_W    = 16;
	localparam int COEFF_W    = 16;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(65536);
	localparam logic [BOOST_W-1:0] BOOST_RST = '0;
	localparam logic [COEFF_W-1:0] COEFF_RST = COEFF_W'(1274);

	// Fixed-point formats.
	localparam int GAIN_FRAC  = 16;
	localparam int BOOST_FRAC = 12;
	localparam int INT_FRAC   = 23;

	// Mid and side in Q.23 never exceed 2^31 in magnitude, the lowpass state
	// is a 32-bit word and the rebuilt left and right stay well inside 42 bits.
	localparam int MS_W  = 33;
	localparam int LP_W  = 32;
	localparam int VAL_W = 42;

	// Soft clip knee (0.9), full scale (1.0) and the range above the knee.
	localparam int KNEE_Q  = 7549747;
	localparam int ONE_Q   = 8388608;
	localparam int RANGE_Q = ONE_Q - KNEE_Q;
	localparam int MAG_W   = 24;

	// The knee is evaluated as R - ceil(R^2 / (R + d)), so the divider only
	// needs the constant numerator R^2. Its quotient is below R.
	localparam int QUO_W = $clog2(RANGE_Q);
	localparam logic [63:0] RANGE_SQ = 64'(RANGE_Q) * 64'(RANGE_Q);
	localparam logic [VAL_W-1:0] CLIP_NUM_HI = VAL_W'(RANGE_SQ >> QUO_W);
	localparam logic [QUO_W-1:0] CLIP_NUM_LO = RANGE_SQ[QUO_W-1:0];

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINEAR_GAIN   = 2'd0,
		CFG_SIDE_BOOST    = 2'd1,
		CFG_LOWPASS_COEFF = 2'd2,
		CFG_WIDEN_ENABLE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_BYP,
		ST_START,
		ST_SIDE,
		ST_CLIP,
		ST_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		LN_IDLE,
		LN_PREP,
		LN_DIV,
		LN_MAG,
		LN_FIN
	} lane_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

[rtl/sgw_clip_lane.sv]
// ----------------------------------------------------------------------------
// Soft clip lane
// Takes one rebuilt channel value in Q.23, applies the rational soft knee
// with a bit-serial divider and rounds and saturates it to the sample width.
// ----------------------------------------------------------------------------
module sgw_clip_lane import sgw_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [VAL_W-1:0]       value,
	output logic signed [SAMPLE_BITS-1:0] result,
	output unit_status_t                  status
);

	localparam int OUT_SH = INT_FRAC - (SAMPLE_BITS - 1);
	localparam int CNT_W  = $clog2(QUO_W);
	localparam logic signed [MAG_W:0] RND_HALF = (MAG_W+1)'((2**OUT_SH) / 2);
	localparam logic signed [MAG_W:0] OUT_HI   = (MAG_W+1)'(2**(SAMPLE_BITS-1) - 1);
	localparam logic signed [MAG_W:0] OUT_LO   = -(MAG_W+1)'(2**(SAMPLE_BITS-1));

	lane_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	logic                   neg_q;
	logic                   over_q;
	logic [VAL_W-1:0]       av_q;
	logic [VAL_W-1:0]       den_q;
	logic [VAL_W-1:0]       rem_q;
	logic [QUO_W-1:0]       num_q;
	logic [QUO_W-1:0]       quo_q;
	logic [MAG_W-1:0]       mag_q;
	logic signed [SAMPLE_BITS-1:0] res_q;

	logic [VAL_W:0]         trial_c;
	logic                   ge_c;
	logic [QUO_W:0]         ceil_c;
	logic signed [MAG_W:0]  ys_c;
	logic signed [MAG_W:0]  rnd_c;
	logic                   last_c;

	assign last_c = (cnt_q == CNT_W'(QUO_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LN_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == LN_DIV) begin
				cnt_q <= last_c ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			LN_IDLE: if (start) state_d = LN_PREP;
			LN_PREP: state_d = LN_DIV;
			LN_DIV:  if (last_c) state_d = LN_MAG;
			LN_MAG:  state_d = LN_FIN;
			LN_FIN:  state_d = LN_IDLE;
			default: state_d = LN_IDLE;
		endcase
	end

	// Restoring division step: one quotient bit per cycle.
	always_comb begin
		trial_c = {rem_q, num_q[QUO_W-1]};
		ge_c    = (trial_c >= {1'b0, den_q});
		ceil_c  = {1'b0, quo_q} + (QUO_W+1)'(rem_q != '0);
		ys_c    = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
		rnd_c   = (ys_c + RND_HALF) >>> OUT_SH;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			LN_IDLE: begin
				if (start) begin
					neg_q <= value[VAL_W-1];
					av_q  <= value[VAL_W-1] ? VAL_W'(-value) : VAL_W'(value);
				end
			end
			LN_PREP: begin
				over_q <= (av_q > VAL_W'(KNEE_Q));
				den_q  <= av_q - VAL_W'(KNEE_Q - RANGE_Q);
				rem_q  <= CLIP_NUM_HI;
				num_q  <= CLIP_NUM_LO;
				quo_q  <= '0;
			end
			LN_DIV: begin
				rem_q <= ge_c ? VAL_W'(trial_c - {1'b0, den_q}) : trial_c[VAL_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], ge_c};
				num_q <= {num_q[QUO_W-2:0], 1'b0};
			end
			LN_MAG: begin
				mag_q <= over_q ? MAG_W'(ONE_Q) - MAG_W'(ceil_c) : av_q[MAG_W-1:0];
			end
			LN_FIN: begin
				if (rnd_c > OUT_HI) begin
					res_q <= OUT_HI[SAMPLE_BITS-1:0];
				end else if (rnd_c < OUT_LO) begin
					res_q <= OUT_LO[SAMPLE_BITS-1:0];
				end else begin
					res_q <= rnd_c[SAMPLE_BITS-1:0];
				end
			end
			default: ;
		endcase
	end

	assign result      = res_q;
	assign status.busy = (state_q != LN_IDLE);
	assign status.done = (state_q == LN_FIN);

endmodule

[rtl/sgw_side_path.sv]
// ----------------------------------------------------------------------------
// Mid/side merge stage
// Combines the two gained lanes into mid and side, runs the side lowpass,
// boosts the part of side above it and rebuilds left and right in Q.23.
// ----------------------------------------------------------------------------
module sgw_side_path import sgw_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COEFF_BITS  = COEFF_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [SAMPLE_BITS+GAIN_W:0]     gl,
	input  logic signed [SAMPLE_BITS+GAIN_W:0]     gr,
	input  logic [BOOST_W-1:0]                     side_boost,
	input  logic [COEFF_W-1:0]                     lowpass_coeff,
	output logic signed [VAL_W-1:0]                left_v,
	output logic signed [VAL_W-1:0]                right_v,
	output unit_status_t                           status
);

	localparam int GW     = SAMPLE_BITS + GAIN_W + 1;
	localparam int SUM_W  = GW + 1;
	localparam int SPLIT  = SAMPLE_BITS - 1 + GAIN_FRAC + 1 - INT_FRAC;
	localparam int DIF_W  = MS_W + 1;
	localparam int PROD_W = DIF_W + COEFF_W + 2;
	localparam int HB_W   = DIF_W + BOOST_W + 1;
	localparam int NSTG   = 8;
	localparam logic [31:0] A_MAX = 32'(1) << COEFF_BITS;
	localparam logic signed [PROD_W:0] LP_MAX =
		{{(PROD_W-LP_W+1){1'b0}}, 1'b0, {(LP_W-1){1'b1}}};
	localparam logic signed [PROD_W:0] LP_MIN =
		{{(PROD_W-LP_W+2){1'b1}}, {(LP_W-1){1'b0}}};

	logic [NSTG-1:0] stg_q;

	logic signed [LP_W-1:0]   lp_q;
	logic signed [MS_W-1:0]   mid_s1;
	logic signed [MS_W-1:0]   side_s1;
	logic signed [DIF_W-1:0]  diff_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [DIF_W-1:0]  high_s5;
	logic signed [HB_W-1:0]   hb_s6;
	logic signed [VAL_W-1:0]  sv_s7;
	logic signed [VAL_W-1:0]  left_s8;
	logic signed [VAL_W-1:0]  right_s8;

	logic signed [SUM_W-1:0]   sum_c;
	logic signed [SUM_W-1:0]   dif_c;
	logic signed [SUM_W-1:0]   midr_c;
	logic signed [SUM_W-1:0]   sider_c;
	logic signed [COEFF_W+1:0] a_c;
	logic signed [BOOST_W:0]   bst_c;
	logic signed [DIF_W-1:0]   hi_c;
	logic signed [PROD_W-1:0]  step_c;
	logic signed [PROD_W:0]    lpn_c;
	logic signed [HB_W-1:0]    hbr_c;

	always_comb begin
		sum_c   = SUM_W'(gl) + SUM_W'(gr);
		dif_c   = SUM_W'(gl) - SUM_W'(gr);
		midr_c  = (sum_c + SUM_W'(2**(SPLIT-1))) >>> SPLIT;
		sider_c = (dif_c + SUM_W'(2**(SPLIT-1))) >>> SPLIT;
		a_c     = (32'(lowpass_coeff) > A_MAX) ? $signed({1'b0, A_MAX[COEFF_W:0]})
		                                       : $signed({2'b0, lowpass_coeff});
		bst_c   = $signed({1'b0, side_boost});
		hi_c    = DIF_W'(side_s1) - DIF_W'(lp_q);
		step_c  = (prod_s3 + PROD_W'(2**(COEFF_BITS-1))) >>> COEFF_BITS;
		lpn_c   = (PROD_W+1)'(lp_q) + (PROD_W+1)'(step_c);
		hbr_c   = (hb_s6 + HB_W'(2**(BOOST_FRAC-1))) >>> BOOST_FRAC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q <= '0;
			lp_q  <= '0;
		end else begin
			stg_q <= {stg_q[NSTG-2:0], start};
			if (stg_q[2]) begin
				if (lpn_c > LP_MAX) begin
					lp_q <= LP_MAX[LP_W-1:0];
				end else if (lpn_c < LP_MIN) begin
					lp_q <= LP_MIN[LP_W-1:0];
				end else begin
					lp_q <= lpn_c[LP_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mid_s1  <= midr_c[MS_W-1:0];
			side_s1 <= sider_c[MS_W-1:0];
		end
		if (stg_q[0]) diff_s2 <= hi_c;
		if (stg_q[1]) prod_s3 <= diff_s2 * a_c;
		if (stg_q[3]) high_s5 <= hi_c;
		if (stg_q[4]) hb_s6 <= high_s5 * bst_c;
		if (stg_q[5]) sv_s7 <= VAL_W'(side_s1) + VAL_W'(hbr_c);
		if (stg_q[6]) begin
			left_s8  <= VAL_W'(mid_s1) + sv_s7;
			right_s8 <= VAL_W'(mid_s1) - sv_s7;
		end
	end

	assign left_v      = left_s8;
	assign right_v     = right_s8;
	assign status.busy = |stg_q;
	assign status.done = stg_q[NSTG-1];

endmodule

[rtl/stereo_gain_widener_softclip.sv]
// ----------------------------------------------------------------------------
// Stereo gain, mid/side widener and soft clipper
// Top level: input and output channels, configuration registers, the two
// gain lanes, the mid/side merge stage and the two soft clip lanes.
// ----------------------------------------------------------------------------
// One stereo frame (left_in, right_in) is transferred on the input channel
// when in_valid is high and in_stall is low; one processed frame is
// transferred on the output channel when out_valid is high and out_stall is
// low. Frames are handled one at a time.
// With widening enabled a frame passes through the gain lanes, the
// eight-stage mid/side and lowpass sequence and the soft clip lanes, whose
// knee divider retires one quotient bit per cycle, before out_valid; the next
// input transfer is possible once the result is handed to the output register.
// With widening disabled a frame goes through gain, then round and saturate.
// The result sits in an output register, so the next frame is taken while it
// waits: a stalled receiver only holds the engine once a second result is
// ready and the register is still occupied.
// Reset clears the control state and the side lowpass and loads the register
// defaults (unity gain, no boost, coefficient 1274, widening off). While reset
// is asserted in_stall is held high, so no frame is taken.
// Configuration writes are taken whenever cfg_we is high; they are meant to
// happen only while no frame is in flight.
// ----------------------------------------------------------------------------
module stereo_gain_widener_softclip import sgw_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COEFF_BITS  = COEFF_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int GW    = SAMPLE_BITS + GAIN_W + 1;
	localparam int LANES = 2;
	localparam logic signed [GW-1:0] SAT_HI = GW'(2**(SAMPLE_BITS-1) - 1);
	localparam logic signed [GW-1:0] SAT_LO = -GW'(2**(SAMPLE_BITS-1));

	// Configuration registers.
	logic [GAIN_W-1:0]  gain_q;
	logic [BOOST_W-1:0] boost_q;
	logic [COEFF_W-1:0] coeff_q;
	logic               widen_q;

	top_state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] smp_q  [LANES];
	logic signed [GW-1:0]          g_s1   [LANES];
	logic signed [SAMPLE_BITS-1:0] byp_q  [LANES];
	logic signed [SAMPLE_BITS-1:0] byp_c  [LANES];
	logic signed [GW-1:0]          bypr_c [LANES];
	logic signed [VAL_W-1:0]       val_c  [LANES];
	logic signed [SAMPLE_BITS-1:0] clip_res [LANES];
	unit_status_t                  ln_st  [LANES];
	unit_status_t                  sd_st;

	logic signed [GAIN_W:0]        gain_c;
	logic                          side_start;
	logic                          out_load;
	logic                          ov_q;
	logic signed [SAMPLE_BITS-1:0] lo_q;
	logic signed [SAMPLE_BITS-1:0] ro_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			boost_q <= BOOST_RST;
			coeff_q <= COEFF_RST;
			widen_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LINEAR_GAIN:   gain_q  <= cfg_data[GAIN_W-1:0];
				CFG_SIDE_BOOST:    boost_q <= cfg_data[BOOST_W-1:0];
				CFG_LOWPASS_COEFF: coeff_q <= cfg_data[COEFF_W-1:0];
				CFG_WIDEN_ENABLE:  widen_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer: gain, then either the bypass saturation or the widening
	// chain, then hand the frame to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		side_start = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_GAIN;
			ST_GAIN: state_d = widen_q ? ST_START : ST_BYP;
			ST_BYP:  state_d = ST_OUT;
			ST_START: begin
				side_start = 1'b1;
				state_d    = ST_SIDE;
			end
			ST_SIDE: if (sd_st.done) state_d = ST_CLIP;
			ST_CLIP: if (ln_st[0].done && ln_st[1].done) state_d = ST_OUT;
			ST_OUT: begin
				if (!ov_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE) || !arst_n;
	assign gain_c   = $signed({1'b0, gain_q});

	// Gain lanes and the bypass round-and-saturate, one per channel.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			bypr_c[i] = (g_s1[i] + GW'(2**(GAIN_FRAC-1))) >>> GAIN_FRAC;
			if (bypr_c[i] > SAT_HI) begin
				byp_c[i] = SAT_HI[SAMPLE_BITS-1:0];
			end else if (bypr_c[i] < SAT_LO) begin
				byp_c[i] = SAT_LO[SAMPLE_BITS-1:0];
			end else begin
				byp_c[i] = bypr_c[i][SAMPLE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			smp_q[0] <= left_in;
			smp_q[1] <= right_in;
		end
		for (int i = 0; i < LANES; i++) begin
			if (state_q == ST_GAIN) g_s1[i] <= smp_q[i] * gain_c;
			if (state_q == ST_BYP) byp_q[i] <= byp_c[i];
		end
	end

	sgw_side_path #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEFF_BITS  (COEFF_BITS)
	) u_side (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (side_start),
		.gl            (g_s1[0]),
		.gr            (g_s1[1]),
		.side_boost    (boost_q),
		.lowpass_coeff (coeff_q),
		.left_v        (val_c[0]),
		.right_v       (val_c[1]),
		.status        (sd_st)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_clip
		sgw_clip_lane #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_clip (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (sd_st.done),
			.value  (val_c[g]),
			.result (clip_res[g]),
			.status (ln_st[g])
		);
	end

	// Output register: frees the engine while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			lo_q <= widen_q ? clip_res[0] : byp_q[0];
			ro_q <= widen_q ? clip_res[1] : byp_q[1];
		end
	end

	assign out_valid = ov_q;
	assign left_out  = lo_q;
	assign right_out = ro_q;

	// The clip lanes pick up the merged values as soon as they are ready.
	a_lanes_start: assert property (@(posedge clk) disable iff (!arst_n)
		sd_st.done |=> (ln_st[0].busy && ln_st[1].busy))
		else $error("clip lanes did not start after the merge stage finished");

	// Both lanes run the same schedule and must finish together.
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		ln_st[0].done == ln_st[1].done)
		else $error("clip lanes finished on different cycles");

	// A new frame is only taken when no unit still works on the last one.
	a_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (!sd_st.busy && !ln_st[0].busy && !ln_st[1].busy))
		else $error("input taken while a unit was still busy");

	// The output register is only filled from the hand-over state.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q == ST_OUT))
		else $error("output register loaded outside the hand-over state");

endmodule
